// File: rtl/ptsrs_pkg.sv
// Shared types and constants for the pan/tilt scan and ranging sequencer.
package ptsrs_pkg;

  // Servo compare value width
  localparam int CMP_W = 13;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_CENTRE    = 3'd0,
    CFG_LOW       = 3'd1,
    CFG_HIGH      = 3'd2,
    CFG_STEP_DOWN = 3'd3,
    CFG_STEP_UP   = 3'd4
  } cfg_index_t;

  // Register reset values
  localparam logic [CMP_W-1:0] CENTRE_RST    = 13'd4625;
  localparam logic [CMP_W-1:0] LOW_RST       = 13'd4375;
  localparam logic [CMP_W-1:0] HIGH_RST      = 13'd4875;
  localparam logic [7:0]       STEP_DOWN_RST = 8'd3;
  localparam logic [7:0]       STEP_UP_RST   = 8'd2;
  localparam logic [CMP_W-1:0] COMPARE_RST   = 13'd4875;

  // Angle: floor((100*(c - centre) + 24930) / 277), clamped to 0..255.
  // Division by 277 is a multiply by ceil(2^25/277); exact for v < 2^25/240.
  localparam logic signed [20:0] ANGLE_GAIN   = 21'sd100;
  localparam logic signed [20:0] ANGLE_OFFSET = 21'sd24930;
  localparam logic [19:0]        ANGLE_SAT    = 20'd70635;  // 255 * 277
  localparam logic [33:0]        ANGLE_RECIP  = 34'd121136;
  localparam int                 ANGLE_SHIFT  = 25;

  // Range: floor(w * 5882 / 16000000) as w * ceil(2^39 * 2941 / 8e6) >> 39,
  // exact for every 16-bit width.
  localparam logic [43:0] RANGE_RECIP = 44'd202103982;
  localparam int          RANGE_SHIFT = 39;

endpackage

// File: rtl/pan_tilt_scan_ranging_sequencer.sv
// Pan/tilt scan sequencer: servo compare stepping, angle and echo range.
// Pipeline: a request's echo width and compares are registered on acceptance,
// then pass through the middle and output registers to the result.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits on out_ready, set by the single shared advance enable.
// Reset: registers return to their defaults, compares to 4875, descending
// pass in its first stage, pipeline empty. No clearing pass.
module pan_tilt_scan_ranging_sequencer #(
  parameter int PERIOD_COUNT = 5000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] rise_capture,
  input  logic [15:0] fall_capture,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pan_angle,
  output logic [7:0]  tilt_angle,
  output logic [7:0]  range_cm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int CW = ptsrs_pkg::CMP_W;
  localparam logic [CW:0] PERIOD_LIM = (CW+1)'(PERIOD_COUNT);

  // Stage codes; the spare code behaves as the first stage
  typedef enum logic [1:0] {
    STG_FIRST  = 2'd0,
    STG_SECOND = 2'd1,
    STG_THIRD  = 2'd2,
    STG_SPARE  = 2'd3
  } stage_t;

  // Configuration registers
  logic [CW-1:0] centre_count;
  logic [CW-1:0] low_limit;
  logic [CW-1:0] high_limit;
  logic [7:0]    step_down;
  logic [7:0]    step_up;

  // Scan state
  logic          ascending;
  stage_t        stage;
  logic [CW-1:0] compare_a;
  logic [CW-1:0] compare_b;
  logic          ascending_next;
  stage_t        stage_next;
  logic [CW-1:0] compare_a_next;
  logic [CW-1:0] compare_b_next;

  // Pipeline
  logic          advance;
  logic          accept;
  logic          v1;
  logic          v2;
  logic [15:0]   width_s1;
  logic [43:0]   range_prod;
  logic [4:0]    range_s2;

  stage_t        st;
  logic          move_b;
  logic [CW-1:0] moving;
  logic [CW-1:0] moved;
  logic [CW:0]   up_sum;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign accept    = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_count <= ptsrs_pkg::CENTRE_RST;
      low_limit    <= ptsrs_pkg::LOW_RST;
      high_limit   <= ptsrs_pkg::HIGH_RST;
      step_down    <= ptsrs_pkg::STEP_DOWN_RST;
      step_up      <= ptsrs_pkg::STEP_UP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptsrs_pkg::CFG_CENTRE:    centre_count <= cfg_data;
        ptsrs_pkg::CFG_LOW:       low_limit    <= cfg_data;
        ptsrs_pkg::CFG_HIGH:      high_limit   <= cfg_data;
        ptsrs_pkg::CFG_STEP_DOWN: step_down    <= cfg_data[7:0];
        ptsrs_pkg::CFG_STEP_UP:   step_up      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // One compare moves per step: B in the second stage, A otherwise
  assign st     = (stage == STG_SPARE) ? STG_FIRST : stage;
  assign move_b = (st == STG_SECOND);
  assign moving = move_b ? compare_b : compare_a;
  assign up_sum = {1'b0, moving} + {{(CW-7){1'b0}}, step_up};

  // Saturating step, clamped to the PWM period
  always_comb begin
    if (ascending) begin
      moved = (up_sum > PERIOD_LIM) ? PERIOD_LIM[CW-1:0] : up_sum[CW-1:0];
    end else if (moving < {{(CW-8){1'b0}}, step_down}) begin
      moved = '0;
    end else if ({1'b0, moving - {{(CW-8){1'b0}}, step_down}} > PERIOD_LIM) begin
      moved = PERIOD_LIM[CW-1:0];
    end else begin
      moved = moving - {{(CW-8){1'b0}}, step_down};
    end
  end

  // Stage sequencing on the moved value
  always_comb begin
    compare_a_next = move_b ? compare_a : moved;
    compare_b_next = move_b ? moved : compare_b;
    ascending_next = ascending;
    stage_next     = st;
    case (st)
      STG_FIRST: begin
        if (ascending ? (moved > centre_count) : (moved < centre_count)) begin
          stage_next = STG_SECOND;
        end
      end
      STG_SECOND: begin
        if (ascending ? (moved > high_limit) : (moved < low_limit)) begin
          stage_next = STG_THIRD;
        end
      end
      default: begin
        if (ascending ? (moved > high_limit) : (moved < low_limit)) begin
          stage_next     = STG_FIRST;
          ascending_next = !ascending;
        end
      end
    endcase
  end

  // Scan state and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      ascending <= 1'b0;
      stage     <= STG_FIRST;
      compare_a <= ptsrs_pkg::COMPARE_RST;
      compare_b <= ptsrs_pkg::COMPARE_RST;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        ascending <= ascending_next;
        stage     <= stage_next;
        compare_a <= compare_a_next;
        compare_b <= compare_b_next;
      end
      if (advance) begin
        v1        <= in_valid;
        v2        <= v1;
        out_valid <= v2;
      end
    end
  end

  // Echo width, then range by reciprocal multiply
  assign range_prod = {28'd0, width_s1} * ptsrs_pkg::RANGE_RECIP;

  always_ff @(posedge clk) begin
    if (accept) begin
      width_s1 <= fall_capture - rise_capture;
    end
    if (advance) begin
      range_s2 <= range_prod[ptsrs_pkg::RANGE_SHIFT+4:ptsrs_pkg::RANGE_SHIFT];
      range_cm <= {3'd0, range_s2};
    end
  end

  // Angles follow the compare registers, which hold the newest request's values
  ptsrs_angle u_pan (
    .clk     (clk),
    .en      (advance),
    .compare (compare_a),
    .centre  (centre_count),
    .angle   (pan_angle)
  );

  ptsrs_angle u_tilt (
    .clk     (clk),
    .en      (advance),
    .compare (compare_b),
    .centre  (centre_count),
    .angle   (tilt_angle)
  );

  // Stalled pipeline never moves the scan
  a_stall_holds_scan: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(compare_a) && $stable(compare_b) && $stable(stage))
    else $error("scan state moved during a stall");

  // Tilt only moves in the second stage
  a_tilt_only_second: assert property (@(posedge clk) disable iff (rst)
    accept && (stage == STG_FIRST || stage == STG_THIRD || stage == STG_SPARE)
    |=> $stable(compare_b))
    else $error("tilt compare moved outside the second stage");

  // A 16-bit echo width never exceeds 24 cm
  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> range_cm <= 8'd24)
    else $error("range result out of bounds");

endmodule

// File: rtl/ptsrs_angle.sv
// Two-stage pipeline that turns a servo compare value into a saturated angle.
module ptsrs_angle (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ptsrs_pkg::CMP_W-1:0]    compare,
  input  logic [ptsrs_pkg::CMP_W-1:0]    centre,
  output logic [7:0]                     angle
);

  logic signed [13:0] diff;
  logic signed [20:0] v;
  logic               neg;
  logic               sat;
  logic               neg_q;
  logic               sat_q;
  logic [16:0]        frac_q;
  logic [33:0]        prod;

  // Offset angle numerator, constant gain
  assign diff = $signed({1'b0, compare}) - $signed({1'b0, centre});
  assign v    = $signed({{7{diff[13]}}, diff}) * ptsrs_pkg::ANGLE_GAIN
                + ptsrs_pkg::ANGLE_OFFSET;
  assign neg  = v[20];
  assign sat  = (v[19:0] >= ptsrs_pkg::ANGLE_SAT);

  // Stage A: clamp flags and the in-range numerator
  always_ff @(posedge clk) begin
    if (en) begin
      neg_q  <= neg;
      sat_q  <= sat;
      frac_q <= v[16:0];
    end
  end

  // Divide by 277 through the reciprocal; quotient stays below 255 here
  assign prod = {17'd0, frac_q} * ptsrs_pkg::ANGLE_RECIP;

  // Stage B: output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_q) begin
        angle <= 8'd0;
      end else if (sat_q) begin
        angle <= 8'hFF;
      end else begin
        angle <= prod[ptsrs_pkg::ANGLE_SHIFT+7:ptsrs_pkg::ANGLE_SHIFT];
      end
    end
  end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the pan/tilt scan and ranging sequencer.
`timescale 1ns / 1ps

module testbench;

  localparam int PERIOD_COUNT = 5000;
  localparam int CMP_W        = ptsrs_pkg::CMP_W;
  localparam int REG_COUNT    = 5;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 155;

  typedef struct packed {
    logic [15:0] rise;
    logic [15:0] fall;
  } echo_t;

  typedef struct packed {
    logic [7:0] pan;
    logic [7:0] tilt;
    logic [7:0] range;
  } reading_t;

  typedef enum logic [1:0] {
    STG_A_CENTRE = 2'd0,
    STG_B_LIMIT  = 2'd1,
    STG_A_LIMIT  = 2'd2
  } scan_stage_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] rise_capture = '0;
  logic [15:0] fall_capture = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pan_angle;
  logic [7:0]  tilt_angle;
  logic [7:0]  range_cm;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  pan_tilt_scan_ranging_sequencer #(
    .PERIOD_COUNT(PERIOD_COUNT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rise_capture(rise_capture),
    .fall_capture(fall_capture),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pan_angle(pan_angle),
    .tilt_angle(tilt_angle),
    .range_cm(range_cm),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: registers and scan position
  logic [CMP_W-1:0] centre_reg    = ptsrs_pkg::CENTRE_RST;
  logic [CMP_W-1:0] low_reg       = ptsrs_pkg::LOW_RST;
  logic [CMP_W-1:0] high_reg      = ptsrs_pkg::HIGH_RST;
  logic [7:0]       step_down_reg = ptsrs_pkg::STEP_DOWN_RST;
  logic [7:0]       step_up_reg   = ptsrs_pkg::STEP_UP_RST;
  logic             rising        = 1'b0;
  scan_stage_t      stage_q       = STG_A_CENTRE;
  logic [CMP_W-1:0] cmp_a         = ptsrs_pkg::COMPARE_RST;
  logic [CMP_W-1:0] cmp_b         = ptsrs_pkg::COMPARE_RST;

  echo_t    capture_q[$];
  reading_t reading_q[$];

  int  mismatches = 0;
  bit  steady = 1'b0;
  bit  in_done = 1'b0;
  int  in_hold = 0;
  int  out_hold = 0;

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly short gaps, a few long ones; none in steady phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [CMP_W-1:0] count_down(input logic [CMP_W-1:0] c);
    int v;
    v = (int'(c) < int'(step_down_reg)) ? 0 : int'(c) - int'(step_down_reg);
    if (v > PERIOD_COUNT) v = PERIOD_COUNT;
    return CMP_W'(v);
  endfunction

  function automatic logic [CMP_W-1:0] count_up(input logic [CMP_W-1:0] c);
    int v;
    v = int'(c) + int'(step_up_reg);
    if (v > PERIOD_COUNT) v = PERIOD_COUNT;
    return CMP_W'(v);
  endfunction

  // Degrees from a compare value, clamped to 0..255
  function automatic logic [7:0] angle_of_count(input logic [CMP_W-1:0] c);
    int v;
    int q;
    v = 100 * (int'(c) - int'(centre_reg)) + 24930;
    if (v < 0) return 8'd0;
    q = v / 277;
    if (q > 255) q = 255;
    return 8'(q);
  endfunction

  // Advance the scan by one step and queue the reading it gives
  task automatic scan_step(input logic [15:0] rise, input logic [15:0] fall);
    reading_t rd;
    logic [15:0] width;
    width = fall - rise;
    if (!rising) begin
      if (stage_q == STG_B_LIMIT) begin
        cmp_b = count_down(cmp_b);
        stage_q = (cmp_b < low_reg) ? STG_A_LIMIT : STG_B_LIMIT;
      end else if (stage_q == STG_A_LIMIT) begin
        cmp_a = count_down(cmp_a);
        if (cmp_a < low_reg) begin
          stage_q = STG_A_CENTRE;
          rising = 1'b1;
        end
      end else begin
        cmp_a = count_down(cmp_a);
        stage_q = (cmp_a < centre_reg) ? STG_B_LIMIT : STG_A_CENTRE;
      end
    end else begin
      if (stage_q == STG_B_LIMIT) begin
        cmp_b = count_up(cmp_b);
        stage_q = (cmp_b > high_reg) ? STG_A_LIMIT : STG_B_LIMIT;
      end else if (stage_q == STG_A_LIMIT) begin
        cmp_a = count_up(cmp_a);
        if (cmp_a > high_reg) begin
          stage_q = STG_A_CENTRE;
          rising = 1'b0;
        end
      end else begin
        cmp_a = count_up(cmp_a);
        stage_q = (cmp_a > centre_reg) ? STG_B_LIMIT : STG_A_CENTRE;
      end
    end
    rd.pan   = angle_of_count(cmp_a);
    rd.tilt  = angle_of_count(cmp_b);
    rd.range = 8'((longint'(width) * 5882) / 16000000);
    reading_q.push_back(rd);
  endtask

  // One register write; the block is idle whenever this is called
  task automatic cfg_write(input logic [2:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (ptsrs_pkg::cfg_index_t'(idx))
      ptsrs_pkg::CFG_CENTRE:    centre_reg    = val;
      ptsrs_pkg::CFG_LOW:       low_reg       = val;
      ptsrs_pkg::CFG_HIGH:      high_reg      = val;
      ptsrs_pkg::CFG_STEP_DOWN: step_down_reg = val[7:0];
      ptsrs_pkg::CFG_STEP_UP:   step_up_reg   = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is taken and every reading has come back
  task automatic drain();
    while (capture_q.size() != 0 || in_valid || reading_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_echo(input logic [15:0] rise, input logic [15:0] fall);
    echo_t e;
    e.rise = rise;
    e.fall = fall;
    capture_q.push_back(e);
  endtask

  function automatic echo_t random_echo();
    echo_t e;
    int r;
    r = $urandom_range(99, 0);
    e.rise = 16'($urandom);
    e.fall = 16'($urandom);
    if (r < 60) begin
      // fully random pair
    end else if (r < 75) begin
      e.fall = e.rise + 16'($urandom_range(30000, 0));
    end else if (r < 85) begin
      e.rise = 16'($urandom_range(65535, 60000));
      e.fall = 16'($urandom_range(5000, 0));
    end else if (r < 92) begin
      e.fall = e.rise;
    end else begin
      e.rise = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
      e.fall = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
    end
    return e;
  endfunction

  function automatic logic [12:0] extreme_count();
    int r;
    r = $urandom_range(99, 0);
    if (r < 25) return 13'd0;
    if (r < 50) return 13'd5000;
    if (r < 60) return 13'h1FFF;
    return 13'($urandom_range(8191, 0));
  endfunction

  function automatic logic [12:0] pick_step();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 13'($urandom_range(40, 1));
    if (r < 70) return 13'd0;
    if (r < 80) return 13'd255;
    if (r < 88) return 13'd1;
    return 13'($urandom);
  endfunction

  // New settings for a random phase: mostly a well-formed scan window
  task automatic pick_settings();
    logic [12:0] centre;
    logic [12:0] low;
    logic [12:0] high;
    if ($urandom_range(99, 0) < 70) begin
      centre = 13'($urandom_range(4000, 1000));
      low    = centre - 13'($urandom_range(800, 20));
      high   = centre + 13'($urandom_range(800, 20));
    end else begin
      centre = extreme_count();
      low    = extreme_count();
      high   = extreme_count();
    end
    cfg_write(ptsrs_pkg::CFG_CENTRE, centre);
    cfg_write(ptsrs_pkg::CFG_LOW, low);
    cfg_write(ptsrs_pkg::CFG_HIGH, high);
    cfg_write(ptsrs_pkg::CFG_STEP_DOWN, pick_step());
    cfg_write(ptsrs_pkg::CFG_STEP_UP, pick_step());
    if ($urandom_range(3, 0) == 0)
      cfg_write(3'($urandom_range(7, REG_COUNT)), 13'($urandom));
  endtask

  // Driver: take requests on the rising edge, present the next on the falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      scan_step(rise_capture, fall_capture);
      in_done = 1'b1;
    end
  end

  always @(negedge clk) begin
    echo_t req;
    if (rst) begin
      in_valid <= 1'b0;
      in_done = 1'b0;
      in_hold = 0;
    end else if (!in_valid || in_done) begin
      in_done = 1'b0;
      if (in_hold != 0) begin
        in_hold--;
        in_valid <= 1'b0;
      end else if (capture_q.size() != 0) begin
        req = capture_q.pop_front();
        rise_capture <= req.rise;
        fall_capture <= req.fall;
        in_valid <= 1'b1;
        in_hold = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else if (out_hold != 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_hold = pick_gap();
    end
  end

  // Monitor: compare each reading with the oldest prediction
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (reading_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: pan %0d tilt %0d range %0d",
                   pan_angle, tilt_angle, range_cm);
      end else begin
        want = reading_q.pop_front();
        if (want.pan !== pan_angle || want.tilt !== tilt_angle || want.range !== range_cm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pan %0d/%0d tilt %0d/%0d range %0d/%0d (expected/actual)",
                     want.pan, pan_angle, want.tilt, tilt_angle, want.range, range_cm);
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    echo_t e;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Capture extremes under the reset settings
    steady = 1'b1;
    push_echo(16'h0000, 16'h0000);
    push_echo(16'h0000, 16'hFFFF);
    push_echo(16'hFFFF, 16'h0000);
    push_echo(16'hFFFF, 16'hFFFF);
    push_echo(16'h0001, 16'h0000);
    push_echo(16'hAAAA, 16'h5555);
    push_echo(16'h5555, 16'hAAAA);
    drain();

    // Full-size steps: quick stage changes
    steady = 1'b0;
    cfg_write(ptsrs_pkg::CFG_STEP_DOWN, 13'd255);
    cfg_write(ptsrs_pkg::CFG_STEP_UP, 13'd255);
    repeat (8) begin
      e = random_echo();
      push_echo(e.rise, e.fall);
    end
    drain();

    // Zero steps hold the stage
    cfg_write(ptsrs_pkg::CFG_STEP_DOWN, 13'd0);
    cfg_write(ptsrs_pkg::CFG_STEP_UP, 13'd0);
    repeat (3) begin
      e = random_echo();
      push_echo(e.rise, e.fall);
    end
    drain();

    // Ignored index, masked step data, unreachable limits
    cfg_write(3'($urandom_range(7, REG_COUNT)), 13'h1FFF);
    cfg_write(ptsrs_pkg::CFG_STEP_UP, 13'h1F05);
    cfg_write(ptsrs_pkg::CFG_STEP_DOWN, 13'h1E07);
    cfg_write(ptsrs_pkg::CFG_CENTRE, 13'd0);
    cfg_write(ptsrs_pkg::CFG_LOW, 13'd0);
    cfg_write(ptsrs_pkg::CFG_HIGH, 13'h1FFF);
    repeat (5) begin
      e = random_echo();
      push_echo(e.rise, e.fall);
    end
    drain();

    // Random phases, each with its own settings
    repeat (RANDOM_PHASES) begin
      pick_settings();
      steady = ($urandom_range(4, 0) == 0);
      @(posedge clk);
      repeat (PHASE_ITEMS) begin
        e = random_echo();
        capture_q.push_back(e);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
